// ===== rtl/fcull_pkg.sv =====
package fcull_pkg;

   localparam int PLANE_COUNT_DEFAULT = 6;
   localparam int PLANE_MAX           = 6;
   localparam int AXES                = 3;

   localparam int WORD_W      = 64;
   localparam int FIELD_W     = 16;
   localparam int CSR_INDEX_W = $clog2(PLANE_MAX);
   localparam int SLOT_W      = 2;
   localparam int SLOT_T      = 3;

   // doubled centre and half extent, Q.8
   localparam int C2_W     = FIELD_W + 1;
   localparam int MA_W     = FIELD_W + 1;
   localparam int PC_W     = FIELD_W + C2_W;
   localparam int PH_W     = MA_W + C2_W;
   // doubled world centre and half extent, Q.16
   localparam int WC_W     = PH_W + 2;
   localparam int TR_SHIFT = 9;
   // doubled plane distance and radius, Q.30
   localparam int PD_W     = FIELD_W + WC_W;
   localparam int PR_W     = MA_W + WC_W;
   localparam int SUM_W    = PR_W + 2;
   localparam int TOT_W    = SUM_W + 1;
   localparam int D_SHIFT  = 23;

   typedef struct packed {
      logic [AXES-1:0][WC_W-1:0] wc;
      logic [AXES-1:0][WC_W-1:0] wh;
   } world_type;

   function automatic logic signed [FIELD_W-1:0] field16(logic [WORD_W-1:0] w,
                                                         logic [SLOT_W-1:0] slot);
      logic [WORD_W-1:0] s;
      s = w >> (FIELD_W * (SLOT_T - int'(slot)));
      return $signed(s[FIELD_W-1:0]);
   endfunction

   function automatic logic signed [MA_W-1:0] abs_ext(logic signed [FIELD_W-1:0] v);
      logic signed [MA_W-1:0] e;
      e = MA_W'(v);
      return e[MA_W-1] ? -e : e;
   endfunction

endpackage

// ===== rtl/fcull_if.sv =====
interface fcull_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [fcull_pkg::WORD_W-1:0]    model_row_x;
   logic        [fcull_pkg::WORD_W-1:0]    model_row_y;
   logic        [fcull_pkg::WORD_W-1:0]    model_row_z;
   logic signed [fcull_pkg::FIELD_W-1:0]   box_min_x;
   logic signed [fcull_pkg::FIELD_W-1:0]   box_min_y;
   logic signed [fcull_pkg::FIELD_W-1:0]   box_min_z;
   logic signed [fcull_pkg::FIELD_W-1:0]   box_max_x;
   logic signed [fcull_pkg::FIELD_W-1:0]   box_max_y;
   logic signed [fcull_pkg::FIELD_W-1:0]   box_max_z;

   modport source (
      output valid, model_row_x, model_row_y, model_row_z,
      output box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      input  ready
   );
   modport sink (
      input  valid, model_row_x, model_row_y, model_row_z,
      input  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      output ready
   );
endinterface

interface fcull_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink   (input valid, visible, output ready);
endinterface

// ===== rtl/fcull_csr.sv =====
module fcull_csr #(
   parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              csr_wr_en,
   input  logic [fcull_pkg::CSR_INDEX_W-1:0]                 csr_index,
   input  logic [fcull_pkg::WORD_W-1:0]                      csr_wr_data,
   output logic [PLANE_COUNT-1:0][fcull_pkg::WORD_W-1:0]     planes
);

   logic [PLANE_COUNT-1:0][fcull_pkg::WORD_W-1:0] planes_ff;
   logic [PLANE_COUNT-1:0][fcull_pkg::WORD_W-1:0] planes_in;

   always_comb begin
      planes_in = planes_ff;
      for (int i = 0; i < PLANE_COUNT; i++) begin
         if (csr_wr_en && csr_index == fcull_pkg::CSR_INDEX_W'(i)) begin
            planes_in[i] = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         planes_ff <= planes_in;
      end
   end

   assign planes = planes_ff;

endmodule

// ===== rtl/fcull_xform.sv =====
module fcull_xform (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic        [fcull_pkg::WORD_W-1:0]     rows    [fcull_pkg::AXES],
   input  logic signed [fcull_pkg::FIELD_W-1:0]    box_min [fcull_pkg::AXES],
   input  logic signed [fcull_pkg::FIELD_W-1:0]    box_max [fcull_pkg::AXES],
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output fcull_pkg::world_type                    out_world
);

   localparam int AXES = fcull_pkg::AXES;

   logic s1_rdy, s2_rdy, s3_rdy;

   // stage 1: doubled centre and half extent
   logic                                  s1_v_ff;
   logic        [fcull_pkg::WORD_W-1:0]   s1_rows_ff [AXES];
   logic signed [fcull_pkg::C2_W-1:0]     s1_c2_ff   [AXES];
   logic signed [fcull_pkg::C2_W-1:0]     s1_h2_ff   [AXES];
   logic signed [fcull_pkg::C2_W-1:0]     s1_c2_in   [AXES];
   logic signed [fcull_pkg::C2_W-1:0]     s1_h2_in   [AXES];

   // stage 2: row by centre and |row| by half extent products
   logic                                  s2_v_ff;
   logic signed [fcull_pkg::PC_W-1:0]     s2_pc_ff [AXES][AXES];
   logic signed [fcull_pkg::PH_W-1:0]     s2_ph_ff [AXES][AXES];
   logic signed [fcull_pkg::FIELD_W-1:0]  s2_t_ff  [AXES];
   logic signed [fcull_pkg::PC_W-1:0]     s2_pc_in [AXES][AXES];
   logic signed [fcull_pkg::PH_W-1:0]     s2_ph_in [AXES][AXES];
   logic signed [fcull_pkg::FIELD_W-1:0]  s2_t_in  [AXES];

   // stage 3: world centre and extent sums
   logic                                  s3_v_ff;
   fcull_pkg::world_type                  s3_world_ff;
   fcull_pkg::world_type                  s3_world_in;

   assign s3_rdy   = !s3_v_ff || out_ready;
   assign s2_rdy   = !s2_v_ff || s3_rdy;
   assign s1_rdy   = !s1_v_ff || s2_rdy;
   assign in_ready = s1_rdy;

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         s1_c2_in[k] = fcull_pkg::C2_W'(box_max[k]) + fcull_pkg::C2_W'(box_min[k]);
         s1_h2_in[k] = fcull_pkg::C2_W'(box_max[k]) - fcull_pkg::C2_W'(box_min[k]);
      end
   end

   always_comb begin
      logic signed [fcull_pkg::FIELD_W-1:0] m;
      for (int r = 0; r < AXES; r++) begin
         for (int k = 0; k < AXES; k++) begin
            m = fcull_pkg::field16(s1_rows_ff[r], fcull_pkg::SLOT_W'(k));
            s2_pc_in[r][k] = fcull_pkg::PC_W'(m) * fcull_pkg::PC_W'(s1_c2_ff[k]);
            s2_ph_in[r][k] = fcull_pkg::PH_W'(fcull_pkg::abs_ext(m))
                           * fcull_pkg::PH_W'(s1_h2_ff[k]);
         end
         s2_t_in[r] = fcull_pkg::field16(s1_rows_ff[r],
                                         fcull_pkg::SLOT_W'(fcull_pkg::SLOT_T));
      end
   end

   always_comb begin
      logic signed [fcull_pkg::WC_W-1:0] acc;
      logic signed [fcull_pkg::WC_W-1:0] ext;
      for (int r = 0; r < AXES; r++) begin
         acc = fcull_pkg::WC_W'(s2_t_ff[r]) <<< fcull_pkg::TR_SHIFT;
         ext = '0;
         for (int k = 0; k < AXES; k++) begin
            acc = acc + fcull_pkg::WC_W'(s2_pc_ff[r][k]);
            ext = ext + fcull_pkg::WC_W'(s2_ph_ff[r][k]);
         end
         s3_world_in.wc[r] = acc;
         s3_world_in.wh[r] = ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_v_ff <= in_valid;
         end
         if (s2_rdy) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_rdy) begin
            s3_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && in_valid) begin
         s1_rows_ff <= rows;
         s1_c2_ff   <= s1_c2_in;
         s1_h2_ff   <= s1_h2_in;
      end
      if (s2_rdy && s1_v_ff) begin
         s2_pc_ff <= s2_pc_in;
         s2_ph_ff <= s2_ph_in;
         s2_t_ff  <= s2_t_in;
      end
      if (s3_rdy && s2_v_ff) begin
         s3_world_ff <= s3_world_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_world = s3_world_ff;

endmodule

// ===== rtl/fcull_test.sv =====
module fcull_test #(
   parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic [PLANE_COUNT-1:0][fcull_pkg::WORD_W-1:0]     planes,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  fcull_pkg::world_type                              in_world,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic                                              out_visible
);

   localparam int AXES = fcull_pkg::AXES;

   logic s4_rdy, s5_rdy, s6_rdy;

   // stage 4: normal by world centre and |normal| by world extent products
   logic                                  s4_v_ff;
   logic signed [fcull_pkg::PD_W-1:0]     s4_pd_ff [PLANE_COUNT][AXES];
   logic signed [fcull_pkg::PR_W-1:0]     s4_pr_ff [PLANE_COUNT][AXES];
   logic signed [fcull_pkg::FIELD_W-1:0]  s4_d_ff  [PLANE_COUNT];
   logic signed [fcull_pkg::PD_W-1:0]     s4_pd_in [PLANE_COUNT][AXES];
   logic signed [fcull_pkg::PR_W-1:0]     s4_pr_in [PLANE_COUNT][AXES];
   logic signed [fcull_pkg::FIELD_W-1:0]  s4_d_in  [PLANE_COUNT];

   // stage 5: distance and radius sums
   logic                                  s5_v_ff;
   logic signed [fcull_pkg::SUM_W-1:0]    s5_dist_ff [PLANE_COUNT];
   logic signed [fcull_pkg::SUM_W-1:0]    s5_rad_ff  [PLANE_COUNT];
   logic signed [fcull_pkg::SUM_W-1:0]    s5_dist_in [PLANE_COUNT];
   logic signed [fcull_pkg::SUM_W-1:0]    s5_rad_in  [PLANE_COUNT];

   // stage 6: sign test and result register
   logic                                  s6_v_ff;
   logic                                  s6_vis_ff;
   logic                                  s6_vis_in;

   assign s6_rdy   = !s6_v_ff || out_ready;
   assign s5_rdy   = !s5_v_ff || s6_rdy;
   assign s4_rdy   = !s4_v_ff || s5_rdy;
   assign in_ready = s4_rdy;

   always_comb begin
      logic signed [fcull_pkg::FIELD_W-1:0] n;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         for (int k = 0; k < AXES; k++) begin
            n = fcull_pkg::field16(planes[p], fcull_pkg::SLOT_W'(k));
            s4_pd_in[p][k] = fcull_pkg::PD_W'(n) * fcull_pkg::PD_W'($signed(in_world.wc[k]));
            s4_pr_in[p][k] = fcull_pkg::PR_W'(fcull_pkg::abs_ext(n))
                           * fcull_pkg::PR_W'($signed(in_world.wh[k]));
         end
         s4_d_in[p] = fcull_pkg::field16(planes[p], fcull_pkg::SLOT_W'(fcull_pkg::SLOT_T));
      end
   end

   always_comb begin
      logic signed [fcull_pkg::SUM_W-1:0] dist_acc;
      logic signed [fcull_pkg::SUM_W-1:0] rad;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         dist_acc = fcull_pkg::SUM_W'(s4_d_ff[p]) <<< fcull_pkg::D_SHIFT;
         rad      = '0;
         for (int k = 0; k < AXES; k++) begin
            dist_acc = dist_acc + fcull_pkg::SUM_W'(s4_pd_ff[p][k]);
            rad      = rad + fcull_pkg::SUM_W'(s4_pr_ff[p][k]);
         end
         s5_dist_in[p] = dist_acc;
         s5_rad_in[p]  = rad;
      end
   end

   always_comb begin
      logic signed [fcull_pkg::TOT_W-1:0] tot;
      s6_vis_in = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         tot = fcull_pkg::TOT_W'(s5_dist_ff[p]) + fcull_pkg::TOT_W'(s5_rad_ff[p]);
         if (tot[fcull_pkg::TOT_W-1]) begin
            s6_vis_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (s4_rdy) begin
            s4_v_ff <= in_valid;
         end
         if (s5_rdy) begin
            s5_v_ff <= s4_v_ff;
         end
         if (s6_rdy) begin
            s6_v_ff <= s5_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy && in_valid) begin
         s4_pd_ff <= s4_pd_in;
         s4_pr_ff <= s4_pr_in;
         s4_d_ff  <= s4_d_in;
      end
      if (s5_rdy && s4_v_ff) begin
         s5_dist_ff <= s5_dist_in;
         s5_rad_ff  <= s5_rad_in;
      end
      if (s6_rdy && s5_v_ff) begin
         s6_vis_ff <= s6_vis_in;
      end
   end

   assign out_valid   = s6_v_ff;
   assign out_visible = s6_vis_ff;

endmodule

// ===== rtl/frustum_aabb_cull.sv =====
// channel   dir   payload                                             transfer
// req_ch    in    model_row_x/y/z, box_min_x/y/z, box_max_x/y/z      valid & ready
// rsp_ch    out   visible                                             valid & ready
// csr_*     in    csr_index, csr_wr_data                              csr_wr_en
//
// One object per cycle while rsp_ch is not stalled; each result passes through
// six register stages: box set-up, model products, world sums, plane products,
// plane sums, sign test into the result register.
// Reset clears all stage valid bits and sets every plane to zero.
// A stalled stage holds; the stages before it keep filling empty slots.
module frustum_aabb_cull #(
   parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   fcull_req_if.sink                           req_ch,
   fcull_rsp_if.source                         rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [fcull_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fcull_pkg::WORD_W-1:0]        csr_wr_data
);

   localparam int AXES = fcull_pkg::AXES;

   logic [PLANE_COUNT-1:0][fcull_pkg::WORD_W-1:0] planes;

   logic        [fcull_pkg::WORD_W-1:0]  rows    [AXES];
   logic signed [fcull_pkg::FIELD_W-1:0] box_min [AXES];
   logic signed [fcull_pkg::FIELD_W-1:0] box_max [AXES];

   logic                 world_valid;
   logic                 world_ready;
   fcull_pkg::world_type world;

   always_comb begin
      rows[0]    = req_ch.model_row_x;
      rows[1]    = req_ch.model_row_y;
      rows[2]    = req_ch.model_row_z;
      box_min[0] = req_ch.box_min_x;
      box_min[1] = req_ch.box_min_y;
      box_min[2] = req_ch.box_min_z;
      box_max[0] = req_ch.box_max_x;
      box_max[1] = req_ch.box_max_y;
      box_max[2] = req_ch.box_max_z;
   end

   fcull_csr #(
      .PLANE_COUNT (PLANE_COUNT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .planes      (planes)
   );

   fcull_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .rows      (rows),
      .box_min   (box_min),
      .box_max   (box_max),
      .out_valid (world_valid),
      .out_ready (world_ready),
      .out_world (world)
   );

   fcull_test #(
      .PLANE_COUNT (PLANE_COUNT)
   ) u_test (
      .clock       (clock),
      .reset       (reset),
      .planes      (planes),
      .in_valid    (world_valid),
      .in_ready    (world_ready),
      .in_world    (world),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_visible (rsp_ch.visible)
   );

endmodule

// ===== rtl/fcull_checker.sv =====
module fcull_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_visible,
   input logic csr_wr_en
);

   // planes stay all zero until the first register write
   logic clean_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clean_ff <= 1'b1;
      end else if (csr_wr_en) begin
         clean_ff <= 1'b0;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visible))
      else $error("stalled result changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled although the output can drain");

   a_zero_planes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clean_ff |-> rsp_visible)
      else $error("box culled by all-zero planes");

endmodule

bind frustum_aabb_cull fcull_checker u_fcull_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_visible (rsp_ch.visible),
   .csr_wr_en   (csr_wr_en)
);
